>>> design/tcl_pkg.sv
`default_nettype none

package tcl_pkg;

    // Screen size defaults, in pixels.
    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    // Stream widths: input and result words, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    // Special byte values.
    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_LEAD = 8'h80;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FONT_WIDTH  = 2'd0,
        CFG_FONT_HEIGHT = 2'd1,
        CFG_LETTER_GAP  = 2'd2,
        CFG_LINE_GAP    = 2'd3
    } cfg_idx_t;

    // Register reset values.
    localparam logic [6:0] FONT_WIDTH_RST  = 7'd16;
    localparam logic [6:0] FONT_HEIGHT_RST = 7'd16;
    localparam logic [7:0] LETTER_GAP_RST  = 8'd0;
    localparam logic [7:0] LINE_GAP_RST    = 8'd0;

    typedef struct packed {
        logic [6:0] font_width;
        logic [6:0] font_height;
        logic [7:0] letter_gap;
        logic [7:0] line_gap;
    } cfg_t;

    typedef struct packed {
        logic [7:0] cursor_x;
        logic [7:0] cursor_y;
        logic [7:0] origin_x;
        logic [7:0] origin_y;
        logic       lead_pending;
        logic [7:0] lead_byte;
        logic       stopped;
    } layout_state_t;

    typedef struct packed {
        logic       first;
        logic [7:0] start_x;
        logic [7:0] start_y;
        logic [7:0] text_byte;
        logic       polarity;
    } text_item_t;

    typedef struct packed {
        logic [7:0]  glyph_x;
        logic [7:0]  glyph_y;
        logic        wide;
        logic [15:0] char_code;
        logic        draw_polarity;
    } glyph_t;

endpackage

`default_nettype wire

>>> design/tcl_step.sv
`default_nettype none

// Layout step for one text byte: works out the next cursor state and the
// glyph that the byte places, if any.
module tcl_step
    import tcl_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  var cfg_t          cfg,
    input  var layout_state_t st,
    input  var text_item_t    item,
    output layout_state_t     st_next,
    output logic              emit,
    output glyph_t            glyph
);

    localparam logic [9:0] SW = 10'(SCREEN_WIDTH);
    localparam logic [9:0] SH = 10'(SCREEN_HEIGHT);

    layout_state_t s_eff;
    logic [6:0]    half_w;
    logic [6:0]    glyph_w;
    logic [7:0]    line_step;
    logic          wrap;
    logic [7:0]    x1;
    logic [7:0]    y1;
    logic          past_bottom;
    logic          is_break;

    // A new string reloads the origin and cursor before the byte is used.
    always_comb begin
        s_eff = st;
        if (item.first) begin
            s_eff.origin_x     = item.start_x;
            s_eff.origin_y     = item.start_y;
            s_eff.cursor_x     = item.start_x;
            s_eff.cursor_y     = item.start_y;
            s_eff.lead_pending = 1'b0;
            s_eff.stopped      = 1'b0;
        end
    end

    // Right-edge wrap, compared on widened values so nothing wraps.
    assign half_w    = {1'b0, cfg.font_width[6:1]};
    assign glyph_w   = s_eff.lead_pending ? cfg.font_width : half_w;
    assign line_step = {1'b0, cfg.font_height} + cfg.line_gap;
    assign wrap      = ({2'b00, s_eff.cursor_x} + {3'b000, glyph_w})
                       > ({2'b00, s_eff.origin_x} + SW);
    assign x1        = wrap ? s_eff.origin_x : s_eff.cursor_x;
    assign y1        = wrap ? (s_eff.cursor_y + line_step) : s_eff.cursor_y;

    // Bottom edge, checked after any wrap.
    assign past_bottom = ({2'b00, y1} + {3'b000, cfg.font_height})
                         > ({2'b00, s_eff.origin_y} + SH);
    assign is_break    = (item.text_byte == BYTE_CR) || (item.text_byte == BYTE_LF);

    // Glyph fields follow the post-wrap cursor.
    always_comb begin
        glyph.glyph_x       = x1;
        glyph.glyph_y       = y1;
        glyph.wide          = s_eff.lead_pending;
        glyph.char_code     = s_eff.lead_pending ? {s_eff.lead_byte, item.text_byte}
                                                 : {8'h00, item.text_byte};
        glyph.draw_polarity = item.polarity;
    end

    // State update and result decision.
    always_comb begin
        st_next = s_eff;
        emit    = 1'b0;
        if (s_eff.stopped) begin
            st_next = s_eff;
        end else if (item.text_byte == BYTE_NUL) begin
            st_next.stopped      = 1'b1;
            st_next.lead_pending = 1'b0;
        end else if (!s_eff.lead_pending && (item.text_byte > BYTE_LEAD)) begin
            st_next.lead_pending = 1'b1;
            st_next.lead_byte    = item.text_byte;
        end else begin
            st_next.lead_pending = 1'b0;
            st_next.cursor_x     = x1;
            st_next.cursor_y     = y1;
            if (past_bottom) begin
                st_next.stopped = 1'b1;
            end else if (!s_eff.lead_pending && is_break) begin
                st_next.cursor_x = s_eff.origin_x;
                st_next.cursor_y = y1 + line_step;
            end else begin
                emit             = 1'b1;
                st_next.cursor_x = x1 + {1'b0, glyph_w} + cfg.letter_gap;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/text_cursor_layout.sv
// Pipeline: two register stages; a result word is loaded into the result
// register once its input word, held in the input register, is processed.
// Throughput: one text byte per cycle while the result output is not stalled;
// the cursor feedback through the layout step is one combinational path.
// Reset: aresetn is synchronous and active low; it clears the cursor state,
// both stage valids and loads the font registers with 16, 16, 0 and 0.
`default_nettype none

module text_cursor_layout
    import tcl_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // start_x[7:0], start_y[15:8], text_byte[23:16], polarity[24], zero[31:25]
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // first[0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // glyph_x[7:0], glyph_y[15:8], char_code[31:16], draw_polarity[32], zero[39:33]
    output logic [M_TDATA_W-1:0]       m_axis_tdata,
    // wide[0]
    output logic                       m_axis_tuser
);

    cfg_t          cfg_reg;
    layout_state_t state_reg;
    layout_state_t state_next;
    logic          in_valid_reg;
    text_item_t    in_item_reg;
    logic          out_valid_reg;
    glyph_t        out_glyph_reg;
    logic          advance;
    logic          step_emit;
    glyph_t        step_glyph;

    // The input word moves on whenever the result register is free or drained.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.font_width  <= FONT_WIDTH_RST;
            cfg_reg.font_height <= FONT_HEIGHT_RST;
            cfg_reg.letter_gap  <= LETTER_GAP_RST;
            cfg_reg.line_gap    <= LINE_GAP_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FONT_WIDTH:  cfg_reg.font_width  <= cfg_wdata[6:0];
                CFG_FONT_HEIGHT: cfg_reg.font_height <= cfg_wdata[6:0];
                CFG_LETTER_GAP:  cfg_reg.letter_gap  <= cfg_wdata;
                CFG_LINE_GAP:    cfg_reg.line_gap    <= cfg_wdata;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.first     <= s_axis_tuser;
            in_item_reg.start_x   <= s_axis_tdata[7:0];
            in_item_reg.start_y   <= s_axis_tdata[15:8];
            in_item_reg.text_byte <= s_axis_tdata[23:16];
            in_item_reg.polarity  <= s_axis_tdata[24];
        end
    end

    tcl_step #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (in_item_reg),
        .st_next (state_next),
        .emit    (step_emit),
        .glyph   (step_glyph)
    );

    // Cursor state commits when the held word is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_valid_reg && advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && step_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && step_emit) begin
            out_glyph_reg <= step_glyph;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_glyph_reg.wide;
    assign m_axis_tdata  = {7'b0000000, out_glyph_reg.draw_polarity,
                            out_glyph_reg.char_code, out_glyph_reg.glyph_y,
                            out_glyph_reg.glyph_x};

endmodule

`default_nettype wire

>>> design/tcl_checker.sv
`default_nettype none

// Port-level checks for the text cursor layout block.
module tcl_checker
    import tcl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    input  wire logic                 s_axis_tready,
    input  wire logic                 m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    input  wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                 m_axis_tuser
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // A fresh result follows a word accepted at the input.
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without an accepted word");

    // Input back-pressure only arises from a waiting result.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with the result register empty");

    // A wide glyph carries a lead byte above 0x80.
    a_wide_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:24] > BYTE_LEAD)
        else $error("wide glyph without a lead byte");

    // A half-width glyph is one byte no higher than 0x80, never a break or terminator.
    a_half_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[31:24] == 8'h00 && m_axis_tdata[23:16] <= BYTE_LEAD &&
            m_axis_tdata[23:16] != BYTE_NUL && m_axis_tdata[23:16] != BYTE_CR &&
            m_axis_tdata[23:16] != BYTE_LF)
        else $error("bad half-width character code");

endmodule

bind text_cursor_layout tcl_checker u_tcl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
